// ===== rtl/core/rbp_pkg.sv =====
// shared types and codes of the reference-counted buffer pool
`default_nettype none

package rbp_pkg;

  // field widths of the channels
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned BYTES_W = 16;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned STAT_W  = 2;

  // largest reference count
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // command codes; unused codes behave as a query
  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_DROP    = 3'd2,
    CMD_SHRINK  = 3'd3,
    CMD_QUERY   = 3'd4,
    CMD_LOAD    = 3'd5
  } cmd_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_COUNT     = 2'd3
  } status_e;

  // input transfer payload
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   slot_index;
    logic [BYTES_W-1:0] size_bytes;
  } in_item_t;

  // output transfer payload
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   granted_index;
    logic [BYTES_W-1:0] usable_size;
    logic [CNT_W-1:0]   ref_count_out;
  } out_item_t;

  // control outcome of one slot update
  typedef struct packed {
    status_e status;
    logic    wr;
    logic    fit;
  } upd_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rbp_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module rbp_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbp_slot_update.sv =====
// next-state logic of one slot entry for every command
`default_nettype none

module rbp_slot_update #(
  parameter int unsigned SIZE_BITS = 16
) (
  input  wire logic [rbp_pkg::CMD_W-1:0] cmd_i,
  input  wire logic                      bad_idx_i,
  input  wire logic [SIZE_BITS-1:0]      size_i,
  input  wire logic [rbp_pkg::CNT_W-1:0] cnt_i,
  input  wire logic [SIZE_BITS-1:0]      cur_i,
  input  wire logic [SIZE_BITS-1:0]      full_i,
  output logic      [rbp_pkg::CNT_W-1:0] cnt_o,
  output logic      [SIZE_BITS-1:0]      cur_o,
  output logic      [SIZE_BITS-1:0]      full_o,
  output rbp_pkg::upd_res_t              res_o
);

  always_comb begin
    cnt_o         = cnt_i;
    cur_o         = cur_i;
    full_o        = full_i;
    res_o.status  = rbp_pkg::STAT_OK;
    res_o.wr      = 1'b0;
    res_o.fit     = 1'b0;
    if (cmd_i == rbp_pkg::CMD_REQUEST) begin
      // first-fit test on the slot under scan
      if (cnt_i == '0 && cur_i >= size_i) begin
        res_o.fit = 1'b1;
        res_o.wr  = 1'b1;
        cnt_o     = rbp_pkg::CNT_W'(1);
        full_o    = cur_i;
      end
    end else if (bad_idx_i) begin
      res_o.status = rbp_pkg::STAT_BAD_INDEX;
    end else begin
      case (cmd_i)
        rbp_pkg::CMD_ADD: begin
          if (cnt_i == rbp_pkg::CNT_MAX) begin
            res_o.status = rbp_pkg::STAT_COUNT;
          end else begin
            cnt_o    = cnt_i + rbp_pkg::CNT_W'(1);
            res_o.wr = 1'b1;
          end
        end
        rbp_pkg::CMD_DROP: begin
          if (cnt_i == '0) begin
            res_o.status = rbp_pkg::STAT_COUNT;
          end else begin
            cnt_o    = cnt_i - rbp_pkg::CNT_W'(1);
            res_o.wr = 1'b1;
            // last reference gone: usable size back to full
            if (cnt_i == rbp_pkg::CNT_W'(1)) begin
              cur_o = full_i;
            end
          end
        end
        rbp_pkg::CMD_SHRINK: begin
          if (size_i < full_i) begin
            cur_o    = size_i;
            res_o.wr = 1'b1;
          end
        end
        rbp_pkg::CMD_LOAD: begin
          cur_o    = size_i;
          full_o   = size_i;
          res_o.wr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/refcounted_buffer_pool.sv =====
// top level of the reference-counted buffer pool with first-fit request
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+------------------------
//   in      | input     | in_item_t   | in_valid_i / in_stall_o
//   out     | output    | out_item_t  | out_valid_o / out_stall_i
//
// one command at a time; slot entries live in one ram with a single read port.
// request: slots examined in order from slot 0 (1..POOL_SLOTS), one ram read each.
// other commands: read, then update and write back.
// reset clears per-slot valid bits at once; an unwritten slot reads as all zero.
// a result waits in the output register; the next command is taken meanwhile,
// and its write back holds until the output register is free.
`default_nettype none

module refcounted_buffer_pool #(
  parameter int unsigned POOL_SLOTS = 8,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rbp_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rbp_pkg::out_item_t     out_item_o
);

  localparam int unsigned AW      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CW      = rbp_pkg::CNT_W;
  localparam int unsigned ENTRY_W = CW + 2 * SIZE_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [rbp_pkg::CMD_W-1:0]   cmd_q;
  logic [rbp_pkg::IDX_W-1:0]   idx_q;
  logic [SIZE_BITS-1:0]        size_q;
  logic                        bad_idx_q;
  logic [AW-1:0]               rd_addr_q;
  logic [POOL_SLOTS-1:0]       slot_vld_q;
  logic                        out_valid_q;
  rbp_pkg::out_item_t          out_item_q, out_item_d;

  logic                        accept;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [ENTRY_W-1:0]          rd_data;
  logic [ENTRY_W-1:0]          wr_data;
  logic                        wr_en;
  logic                        entry_vld;
  logic [CW-1:0]               cnt_rd, cnt_nx;
  logic [SIZE_BITS-1:0]        cur_rd, cur_nx, full_rd, full_nx;
  rbp_pkg::upd_res_t           upd;
  logic                        can_finish;
  logic                        last_slot;
  logic                        finish;
  logic                        in_is_req;
  logic                        in_bad_idx;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign can_finish = !out_valid_q || !out_stall_i;
  assign last_slot  = (rd_addr_q == AW'(POOL_SLOTS - 1));
  assign in_is_req  = (in_item_i.command == rbp_pkg::CMD_REQUEST);
  assign in_bad_idx = ({1'b0, in_item_i.slot_index} >= (rbp_pkg::IDX_W + 1)'(POOL_SLOTS));

  // slot entry memory: {count, current size, full size}
  rbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_SLOTS)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (rd_addr_q),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // unwritten slots read as zero
  assign entry_vld = slot_vld_q[rd_addr_q];
  assign cnt_rd    = entry_vld ? rd_data[ENTRY_W-1 -: CW] : '0;
  assign cur_rd    = entry_vld ? rd_data[2*SIZE_BITS-1 -: SIZE_BITS] : '0;
  assign full_rd   = entry_vld ? rd_data[SIZE_BITS-1:0] : '0;
  assign wr_data   = {cnt_nx, cur_nx, full_nx};

  rbp_slot_update #(
    .SIZE_BITS (SIZE_BITS)
  ) u_update (
    .cmd_i     (cmd_q),
    .bad_idx_i (bad_idx_q),
    .size_i    (size_q),
    .cnt_i     (cnt_rd),
    .cur_i     (cur_rd),
    .full_i    (full_rd),
    .cnt_o     (cnt_nx),
    .cur_o     (cur_nx),
    .full_o    (full_nx),
    .res_o     (upd)
  );

  // sequencer: read issue, scan stepping and completion
  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = rd_addr_q;
    finish  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_en   = 1'b1;
          rd_addr = in_is_req ? '0 : in_item_i.slot_index[AW-1:0];
          state_d = in_is_req ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (upd.fit || last_slot) begin
          finish = can_finish;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_addr_q + AW'(1);
        end
      end
      S_EXEC: begin
        finish = can_finish;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (finish) begin
      state_d = S_IDLE;
    end
  end

  assign wr_en = finish && upd.wr;

  // result formation
  always_comb begin
    out_item_d               = '0;
    out_item_d.granted_index = idx_q;
    if (cmd_q == rbp_pkg::CMD_REQUEST) begin
      if (upd.fit) begin
        out_item_d.status        = rbp_pkg::STAT_OK;
        out_item_d.granted_index = rbp_pkg::IDX_W'(rd_addr_q);
        out_item_d.usable_size   = rbp_pkg::BYTES_W'(cur_nx);
        out_item_d.ref_count_out = cnt_nx;
      end else begin
        out_item_d.status        = rbp_pkg::STAT_NO_FREE;
        out_item_d.granted_index = '0;
      end
    end else if (bad_idx_q) begin
      out_item_d.status = rbp_pkg::STAT_BAD_INDEX;
    end else begin
      out_item_d.status        = upd.status;
      out_item_d.usable_size   = rbp_pkg::BYTES_W'(cur_nx);
      out_item_d.ref_count_out = cnt_nx;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_addr_q   <= '0;
      slot_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rd_en) begin
        rd_addr_q <= rd_addr;
      end
      if (wr_en) begin
        slot_vld_q[rd_addr_q] <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command and result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_item_i.command;
      idx_q     <= in_item_i.slot_index;
      size_q    <= SIZE_BITS'(in_item_i.size_bytes);
      bad_idx_q <= in_bad_idx;
    end
    if (finish) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
